// ===== design/prle_pkg.sv =====
// Types and constants shared by the run-length scanline decoder modules.
package prle_pkg;

  localparam int unsigned ColW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_LAYOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COLOR_CODED = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_CODED = 2'd3;

  localparam logic [1:0] LAYOUT_RGBA = 2'd1;
  localparam logic [1:0] LAYOUT_SPLIT = 2'd2;

  localparam logic [7:0] HDR_LONG_RUN = 8'd128;
  localparam logic [7:0] HDR_REPEAT_BIAS = 8'd127;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_COUNT_HI = 5'b00010,
    PH_COUNT_LO = 5'b00100,
    PH_LITERAL  = 5'b01000,
    PH_REPEAT   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ColW-1:0] row_width;
    logic [1:0]      channel_layout;
    logic            color_coded;
    logic            alpha_coded;
  } cfg_t;

  typedef struct packed {
    phase_t          phase;
    logic [ColW-1:0] column;
    logic [7:0]      literal_left;
    logic [ColW-1:0] pending_count;
    logic [1:0]      byte_in_pixel;
    logic [31:0]     pixel_bytes;
    logic            alpha_part;
    logic            stuck_error;
  } dec_state_t;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic            in_alpha_part;
    logic [ColW-1:0] start_column;
    logic [ColW-1:0] run_count;
    logic            part_done;
    logic            overrun_error;
  } run_rec_t;

endpackage

// ===== design/prle_step.sv =====
// Next-state and run record logic for one data word of the scanline decoder.
module prle_step import prle_pkg::*; (
  input  cfg_t       cfg,
  input  dec_state_t cur,
  input  logic [7:0] data_byte,
  output dec_state_t nxt,
  output logic       rec_valid,
  output run_rec_t   rec
);

  logic            coded;
  logic [ColW-1:0] hdr_count;
  logic [ColW-1:0] chk_count;
  logic            over;
  logic            do_pixel;
  logic [1:0]      bip;
  logic [31:0]     pxb;
  logic [31:0]     px;
  logic [1:0]      bip_inc;
  logic [2:0]      psize;
  logic            pix_done;
  logic [ColW-1:0] run_cnt;
  logic [ColW:0]   col_sum;
  logic [7:0]      lit_dec;

  assign coded = cur.alpha_part ? cfg.alpha_coded : cfg.color_coded;

  always_comb begin
    if (!coded) begin
      hdr_count = ColW'(1);
    end else if (data_byte < HDR_LONG_RUN) begin
      hdr_count = ColW'({1'b0, data_byte} + 9'd1);
    end else begin
      hdr_count = ColW'(data_byte - HDR_REPEAT_BIAS);
    end
    chk_count = (cur.phase == PH_COUNT_LO) ? {cur.pending_count[15:8], data_byte} : hdr_count;
    over = ({1'b0, cur.column} + {1'b0, chk_count}) > {1'b0, cfg.row_width};
  end

  assign psize = cur.alpha_part ? 3'd1 :
                 (cfg.channel_layout == LAYOUT_RGBA) ? 3'd4 : 3'd3;

  always_comb begin
    nxt       = cur;
    rec_valid = 1'b0;
    rec       = '0;
    do_pixel  = 1'b0;
    bip       = cur.byte_in_pixel;
    pxb       = cur.pixel_bytes;
    run_cnt   = cur.pending_count;
    px        = '0;
    bip_inc   = '0;
    pix_done  = 1'b0;
    col_sum   = '0;
    lit_dec   = '0;

    if (!cur.stuck_error) begin
      unique case (cur.phase)
        PH_HEADER: begin
          if (over && (!coded || data_byte != HDR_LONG_RUN)) begin
            rec_valid = 1'b1;
          end else if (!coded) begin
            nxt.pending_count = ColW'(1);
            nxt.phase = PH_REPEAT;
            bip = '0;
            pxb = '0;
            run_cnt = ColW'(1);
            do_pixel = 1'b1;
          end else if (data_byte < HDR_LONG_RUN) begin
            nxt.literal_left = hdr_count[7:0];
            nxt.phase = PH_LITERAL;
            nxt.byte_in_pixel = '0;
            nxt.pixel_bytes = '0;
          end else if (data_byte == HDR_LONG_RUN) begin
            nxt.phase = PH_COUNT_HI;
          end else begin
            nxt.pending_count = hdr_count;
            nxt.phase = PH_REPEAT;
            nxt.byte_in_pixel = '0;
            nxt.pixel_bytes = '0;
          end
        end
        PH_COUNT_HI: begin
          nxt.pending_count = {data_byte, 8'h00};
          nxt.phase = PH_COUNT_LO;
        end
        PH_COUNT_LO: begin
          nxt.pending_count = chk_count;
          if (over) begin
            rec_valid = 1'b1;
          end else begin
            nxt.phase = PH_REPEAT;
            nxt.byte_in_pixel = '0;
            nxt.pixel_bytes = '0;
          end
        end
        PH_LITERAL: begin
          run_cnt = ColW'(1);
          do_pixel = 1'b1;
        end
        PH_REPEAT: begin
          do_pixel = 1'b1;
        end
        default: begin
          nxt.phase = PH_HEADER;
        end
      endcase

      if (rec_valid) begin
        nxt.stuck_error   = 1'b1;
        rec.in_alpha_part = cur.alpha_part;
        rec.start_column  = cur.column;
        rec.run_count     = chk_count;
        rec.overrun_error = 1'b1;
      end

      if (do_pixel) begin
        unique case (bip)
          2'd0: px = pxb | {24'h0, data_byte};
          2'd1: px = pxb | {16'h0, data_byte, 8'h0};
          2'd2: px = pxb | {8'h0, data_byte, 16'h0};
          default: px = pxb | {data_byte, 24'h0};
        endcase
        bip_inc  = bip + 2'd1;
        pix_done = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= psize);
        if (!pix_done) begin
          nxt.byte_in_pixel = bip_inc;
          nxt.pixel_bytes = px;
        end else begin
          nxt.byte_in_pixel = '0;
          nxt.pixel_bytes = '0;
          if (run_cnt == '0) begin
            nxt.phase = PH_HEADER;
          end else begin
            rec_valid = 1'b1;
            if (cur.alpha_part) begin
              rec.alpha = px[7:0];
              rec.in_alpha_part = 1'b1;
            end else begin
              rec.red   = px[7:0];
              rec.green = px[15:8];
              rec.blue  = px[23:16];
              if (cfg.channel_layout == LAYOUT_RGBA) begin
                rec.alpha = px[31:24];
              end
            end
            rec.start_column = cur.column;
            rec.run_count = run_cnt;
            col_sum = {1'b0, cur.column} + {1'b0, run_cnt};
            lit_dec = cur.literal_left - 8'd1;
            if (col_sum >= {1'b0, cfg.row_width}) begin
              rec.part_done = 1'b1;
              nxt.column = '0;
              nxt.literal_left = '0;
              nxt.phase = PH_HEADER;
              if (cur.alpha_part) begin
                nxt.alpha_part = 1'b0;
              end else if (cfg.channel_layout == LAYOUT_SPLIT) begin
                nxt.alpha_part = 1'b1;
              end
            end else begin
              nxt.column = col_sum[ColW-1:0];
              if (cur.phase == PH_LITERAL) begin
                nxt.literal_left = lit_dec;
                if (lit_dec == '0) begin
                  nxt.phase = PH_HEADER;
                end
              end else begin
                nxt.phase = PH_HEADER;
              end
            end
          end
        end
      end
    end
  end

endmodule

// ===== design/pic_rle_scanline_decoder_top.sv =====
// Top level of the mixed run-length scanline decoder: word registers, state and config.
//
//   channel   handshake               payload
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//   in        in_valid / in_ready     data_byte
//   out       out_valid / out_ready   red .. overrun_error
//
// Each data word passes through the step logic, from the input word register to the result
// register, so one word per cycle is sustained while results are taken.
// A held result still lets one further word be taken into the input register.
// Reset clears the decoder state and loads the register defaults; no clearing pass.
// Configuration writes are taken in every cycle and act at once.
module pic_rle_scanline_decoder_top import prle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  output logic                in_alpha_part,
  output logic [ColW-1:0]     start_column,
  output logic [ColW-1:0]     run_count,
  output logic                part_done,
  output logic                overrun_error
);

  cfg_t       cfg;
  dec_state_t state;
  dec_state_t state_next;
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       rec_valid;
  run_rec_t   rec_next;
  run_rec_t   rec;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  prle_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .data_byte (in_byte),
    .nxt       (state_next),
    .rec_valid (rec_valid),
    .rec       (rec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width      <= ColW'(1);
      cfg.channel_layout <= '0;
      cfg.color_coded    <= 1'b1;
      cfg.alpha_coded    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:      cfg.row_width <= cfg_data[ColW-1:0];
        REG_CHANNEL_LAYOUT: cfg.channel_layout <= cfg_data[1:0];
        REG_COLOR_CODED:    cfg.color_coded <= cfg_data[0];
        REG_ALPHA_CODED:    cfg.alpha_coded <= cfg_data[0];
        default:            cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_HEADER;
      state.column        <= '0;
      state.literal_left  <= '0;
      state.pending_count <= '0;
      state.byte_in_pixel <= '0;
      state.pixel_bytes   <= '0;
      state.alpha_part    <= 1'b0;
      state.stuck_error   <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= rec_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rec_valid) begin
      rec <= rec_next;
    end
  end

  assign red           = rec.red;
  assign green         = rec.green;
  assign blue          = rec.blue;
  assign alpha         = rec.alpha;
  assign in_alpha_part = rec.in_alpha_part;
  assign start_column  = rec.start_column;
  assign run_count     = rec.run_count;
  assign part_done     = rec.part_done;
  assign overrun_error = rec.overrun_error;

endmodule
